// File: rtl/core/nlep_pkg.sv
// ----------------------------------------------------------------------------
// nlep_pkg
// Shared constants for the numeric line entry parser: character codes,
// register indexes and counter width.
// ----------------------------------------------------------------------------
package nlep_pkg;

  localparam int COUNT_BITS = 16;

  localparam logic [7:0] CR_CODE    = 8'h0D;
  localparam logic [7:0] ERASE_INIT = 8'h08;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;

  // digit code with bit 4 set means "not a digit"
  localparam logic [4:0] NO_DIGIT   = 5'h10;
  localparam logic [4:0] DIGIT_TEN  = 5'h0A;

  // configuration register indexes
  localparam logic REG_RADIX_HEX  = 1'b0;
  localparam logic REG_ERASE_CODE = 1'b1;

  // reciprocal of ten for a 32-bit dividend, quotient is product >> 35
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

endpackage

// File: rtl/core/numeric_line_entry_parser.sv
// ----------------------------------------------------------------------------
// numeric_line_entry_parser
// Builds an unsigned 32-bit number from received characters, decimal or hex.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle unless the input stalls. The
// character lands in an input register, is decoded against the number held
// so far, and the echo or the finished number, if any, is placed in a result
// register. The longest path is the divide by ten on a decimal erase, a 32 by 32
// constant multiply between the accumulator and its next value. The input
// stalls only while the input register is full and the result register
// holds a result that is itself stalled. Ignored characters and erases with
// no digits give no result. Configuration writes are taken at any edge with
// cfg_we high and should only be made while the block is idle.
module numeric_line_entry_parser
  import nlep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // character input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_char,
  // results
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_final,
  output logic [7:0]  echo_char,
  output logic [31:0] value
);

  logic                  radix_hex;
  logic [7:0]            erase_code;
  logic [31:0]           accum;
  logic [31:0]           accum_next;
  logic [COUNT_BITS-1:0] digit_count;
  logic [COUNT_BITS-1:0] digit_count_next;

  logic                  held_valid;
  logic [7:0]            held_char;

  logic                  advance;
  logic [4:0]            digit;
  logic                  emit;
  logic                  emit_final;

  logic [63:0]           prod_ten;
  logic [31:0]           accum_div;
  logic [31:0]           accum_mul;

  assign advance  = held_valid && (!out_valid || !out_stall);
  assign in_stall = held_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix_hex  <= 1'b0;
      erase_code <= ERASE_INIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX_HEX:  radix_hex  <= cfg_data[0];
        REG_ERASE_CODE: erase_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_char <= rx_char;
    end
  end

  always_comb begin
    digit = NO_DIGIT;
    if (held_char inside {[CHAR_0:CHAR_9]}) begin
      digit = 5'(held_char - CHAR_0);
    end else if (radix_hex && (held_char inside {[CHAR_UA:CHAR_UF]})) begin
      digit = 5'(held_char - CHAR_UA) + DIGIT_TEN;
    end else if (radix_hex && (held_char inside {[CHAR_LA:CHAR_LF]})) begin
      digit = 5'(held_char - CHAR_LA) + DIGIT_TEN;
    end
  end

  assign prod_ten  = {32'b0, accum} * {32'b0, RECIP_TEN};
  assign accum_div = radix_hex ? {4'b0, accum[31:4]} : 32'(prod_ten >> RECIP_SHIFT);
  assign accum_mul = radix_hex ? {accum[27:0], 4'b0}
                               : ({accum[28:0], 3'b0} + {accum[30:0], 1'b0});

  always_comb begin
    accum_next       = accum;
    digit_count_next = digit_count;
    emit             = 1'b0;
    emit_final       = 1'b0;
    if (held_char == CR_CODE) begin
      accum_next       = '0;
      digit_count_next = '0;
      emit             = 1'b1;
      emit_final       = 1'b1;
    end else if (!digit[4]) begin
      accum_next = accum_mul + {28'b0, digit[3:0]};
      if (digit_count != COUNT_MAX) begin
        digit_count_next = digit_count + 1'b1;
      end
      emit = 1'b1;
    end else if (held_char == erase_code && digit_count != '0) begin
      accum_next       = accum_div;
      digit_count_next = digit_count - 1'b1;
      emit             = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum       <= '0;
      digit_count <= '0;
    end else if (advance) begin
      accum       <= accum_next;
      digit_count <= digit_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_final  <= emit_final;
      echo_char <= emit_final ? 8'h00 : held_char;
      value     <= emit_final ? accum : 32'h0;
    end
  end

endmodule

// File: rtl/core/nlep_checker.sv
// ----------------------------------------------------------------------------
// nlep_checker
// Port-level checks for the numeric line entry parser, bound to the top level.
// ----------------------------------------------------------------------------
module nlep_checker
  import nlep_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        is_final,
  input logic [7:0]  echo_char,
  input logic [31:0] value
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_final)
      && $stable(echo_char) && $stable(value))
    else $error("stalled result changed");

  a_echo_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_final |-> value == 32'h0)
    else $error("echo result carries a value");

  a_final_zero_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_final |-> echo_char == 8'h00)
    else $error("finished result carries a character");

  a_no_cr_echo: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_final |-> echo_char != CR_CODE)
    else $error("carriage return echoed");

  // a finish straight after a finish sees a cleared number
  a_final_cleared: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_final && !out_stall |=> !(out_valid && is_final) || value == 32'h0)
    else $error("number not cleared after finish");

endmodule

bind numeric_line_entry_parser nlep_checker u_nlep_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .is_final  (is_final),
  .echo_char (echo_char),
  .value     (value)
);
